// ===== rtl/bdph_pkg.sv =====
`default_nettype none

package bdph_pkg;

   localparam int BUTTONS     = 6;
   localparam int PORT_BITS   = 6;
   localparam int BTN_IDX_W   = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
   localparam int COUNT_W     = 8;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [1:0] {
      CMD_TICK        = 2'd0,
      CMD_QUERY       = 2'd1,
      CMD_QUERY_CLEAR = 2'd2,
      CMD_UNUSED      = 2'd3
   } cmd_type;

   // Register numbers, taken from address bit 2 of paddr.
   localparam logic REG_HOLD_TICKS  = 1'b0;
   localparam logic REG_PRESS_LEVEL = 1'b1;

   localparam logic [COUNT_W-1:0] HOLD_TICKS_RESET = 8'd100;

   typedef struct packed {
      logic [1:0] command;
      logic [5:0] port_sample;
      logic [2:0] button_index;
   } req_type;

   typedef struct packed {
      logic [7:0] held_count;
      logic       short_press;
      logic       long_press;
      logic       bad_index;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/button_debounce_press_hold.sv =====
// A query word is taken into the input register and its result is then
// registered in the result register; a sample tick gives no result.
// Throughput: one word per cycle; the input stage holds only while a query
// waits on a result register that has not been taken.
// Reset (synchronous, active high) clears all samples, counters and flags,
// sets hold_ticks to 100 and press_level to 0, and empties both stages.
`default_nettype none

module button_debounce_press_hold
   import bdph_pkg::*;
(
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output rsp_type                 rsp_data,
   input  wire                     csr_psel,
   input  wire                     csr_penable,
   input  wire                     csr_pwrite,
   input  wire  [CSR_ADDR_W-1:0]   csr_paddr,
   input  wire  [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   logic [COUNT_W-1:0] hold_ticks_ff;
   logic               press_level_ff;

   logic               in_vld_ff;
   req_type            in_word_ff;

   logic [BUTTONS-1:0] newer_ff, newer_in;
   logic [BUTTONS-1:0] older_ff, older_in;
   logic [COUNT_W-1:0] count_ff [BUTTONS];
   logic [COUNT_W-1:0] count_in [BUTTONS];
   logic [BUTTONS-1:0] short_ff, short_in;
   logic [BUTTONS-1:0] long_ff, long_in;

   logic               rsp_vld_ff;
   rsp_type            rsp_word_ff, rsp_word_in;

   logic               csr_wr;
   logic               is_query;
   logic               out_free;
   logic               in_go;
   logic               bad_idx;
   logic [BTN_IDX_W-1:0] sel;
   logic [BUTTONS-1:0] port_ext;
   cmd_type            cmd;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[2])
         REG_HOLD_TICKS:  csr_prdata[COUNT_W-1:0] = hold_ticks_ff;
         REG_PRESS_LEVEL: csr_prdata[0]           = press_level_ff;
         default:         csr_prdata              = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff  <= HOLD_TICKS_RESET;
         press_level_ff <= 1'b0;
      end else if (csr_wr) begin
         if (csr_paddr[2] == REG_HOLD_TICKS) begin
            hold_ticks_ff <= csr_pwdata[COUNT_W-1:0];
         end else begin
            press_level_ff <= csr_pwdata[0];
         end
      end
   end

   // ---------------- handshake ----------------
   assign cmd       = cmd_type'(in_word_ff.command);
   assign is_query  = (cmd == CMD_QUERY) || (cmd == CMD_QUERY_CLEAR);
   assign out_free  = !rsp_vld_ff || rsp_ready;
   assign in_go     = in_vld_ff && (!is_query || out_free);
   assign req_ready = !in_vld_ff || in_go;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_word_ff <= req_data;
      end
   end

   // ---------------- debounce and query logic ----------------
   assign port_ext = BUTTONS'(in_word_ff.port_sample);
   assign bad_idx  = ({1'b0, in_word_ff.button_index} >= 4'(BUTTONS));
   assign sel      = in_word_ff.button_index[BTN_IDX_W-1:0];

   always_comb begin
      logic lvl;
      newer_in    = newer_ff;
      older_in    = older_ff;
      count_in    = count_ff;
      short_in    = short_ff;
      long_in     = long_ff;
      rsp_word_in = '0;
      if (in_go) begin
         unique case (cmd)
            CMD_TICK: begin
               for (int k = 0; k < BUTTONS; k++) begin
                  // Pins past the port width always read as level zero.
                  lvl         = (k < PORT_BITS) ? port_ext[k] : 1'b0;
                  older_in[k] = newer_ff[k];
                  newer_in[k] = lvl;
                  if (lvl == newer_ff[k]) begin
                     if (lvl == press_level_ff) begin
                        if (count_ff[k] < hold_ticks_ff) begin
                           count_in[k] = count_ff[k] + 8'd1;
                        end else begin
                           long_in[k] = 1'b1;
                        end
                     end else begin
                        short_in[k] = (count_ff[k] != '0) && !long_ff[k];
                        count_in[k] = '0;
                        long_in[k]  = 1'b0;
                     end
                  end
               end
            end
            CMD_QUERY, CMD_QUERY_CLEAR: begin
               if (bad_idx) begin
                  rsp_word_in.bad_index = 1'b1;
               end else begin
                  rsp_word_in.held_count  = count_ff[sel];
                  rsp_word_in.short_press = short_ff[sel];
                  rsp_word_in.long_press  = long_ff[sel];
                  if (cmd == CMD_QUERY_CLEAR) begin
                     short_in[sel] = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         newer_ff <= '0;
         older_ff <= '0;
         short_ff <= '0;
         long_ff  <= '0;
         for (int k = 0; k < BUTTONS; k++) begin
            count_ff[k] <= '0;
         end
      end else begin
         newer_ff <= newer_in;
         older_ff <= older_in;
         short_ff <= short_in;
         long_ff  <= long_in;
         count_ff <= count_in;
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (out_free) begin
         rsp_vld_ff <= in_go && is_query;
      end
      if (in_go && is_query) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bdph_checker.sv =====
`default_nettype none

module bdph_checker
   import bdph_pkg::*;
(
   input wire     clock,
   input wire     reset,
   input wire     rsp_valid,
   input wire     rsp_ready,
   input rsp_type rsp_data,
   input wire     csr_pready
);

   // A result word that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped before it was taken");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A query of a missing button reports nothing but the error bit.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_index |->
         rsp_data.held_count == '0 && !rsp_data.short_press && !rsp_data.long_press)
      else $error("out-of-range query carries data");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("register port stalled");

endmodule

bind button_debounce_press_hold bdph_checker u_bdph_checker (.*);

`default_nettype wire

// ===== sim/button_debounce_press_hold_tb.sv =====
`timescale 1ns / 1ps

module button_debounce_press_hold_tb;
   import bdph_pkg::*;

   localparam int LONG_STALL_CYCLES = 300;
   localparam int SETTLE_CYCLES     = 4;

   typedef enum int {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_MOSTLY} ready_style_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   button_debounce_press_hold uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Debouncer state as the block should hold it.
   logic [COUNT_W-1:0] hold_cfg = HOLD_TICKS_RESET;
   logic               press_cfg = 1'b0;
   logic [BUTTONS-1:0] newer_level = '0;
   logic [BUTTONS-1:0] older_level = '0;
   logic [BUTTONS-1:0] short_seen = '0;
   logic [BUTTONS-1:0] long_seen = '0;
   logic [COUNT_W-1:0] hold_count [BUTTONS] = '{default: '0};

   req_type pending_words [$];
   rsp_type expected_status [$];
   int      error_count = 0;

   // Random tick content: one pin pattern is held for a run of ticks.
   logic [PORT_BITS-1:0] held_pattern = '0;
   int                   run_left = 0;

   int burst_left = 0;
   int gap_left = 0;

   int              stall_asked = 0;
   int              stall_taken = 0;
   int              stall_left = 0;
   ready_style_type ready_mode = READY_ALWAYS;
   int              ready_mode_left = 0;

   rsp_type got_status;
   rsp_type want_status;

   function automatic void debounce_predict(req_type w);
      logic    lvl;
      rsp_type st;
      int      idx;
      case (w.command)
         CMD_TICK: begin
            for (int k = 0; k < BUTTONS; k++) begin
               lvl = (k < PORT_BITS) ? w.port_sample[k] : 1'b0;
               older_level[k] = newer_level[k];
               newer_level[k] = lvl;
               if (older_level[k] == lvl) begin
                  if (lvl == press_cfg) begin
                     if (hold_count[k] < hold_cfg)
                        hold_count[k] = hold_count[k] + 1'b1;
                     else
                        long_seen[k] = 1'b1;
                  end else begin
                     short_seen[k] = (hold_count[k] != 0) && !long_seen[k];
                     hold_count[k] = '0;
                     long_seen[k] = 1'b0;
                  end
               end
            end
         end
         CMD_QUERY, CMD_QUERY_CLEAR: begin
            idx = w.button_index;
            st = '0;
            if (idx >= BUTTONS) begin
               st.bad_index = 1'b1;
            end else begin
               st.held_count = hold_count[idx];
               st.short_press = short_seen[idx];
               st.long_press = long_seen[idx];
               if (w.command == CMD_QUERY_CLEAR)
                  short_seen[idx] = 1'b0;
            end
            expected_status.push_back(st);
         end
         default: begin
         end
      endcase
   endfunction

   // Sender: bursts of words with random gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            debounce_predict(req_data);
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               req_data <= pending_words.pop_front();
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: a changing stall pattern, plus a long hold-off when asked for.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (stall_taken != stall_asked) begin
         stall_taken = stall_asked;
         stall_left = LONG_STALL_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         if (ready_mode_left == 0) begin
            ready_mode = ready_style_type'($urandom_range(0, 3));
            ready_mode_left = $urandom_range(8, 64);
         end else begin
            ready_mode_left--;
         end
         case (ready_mode)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_HALF:   rsp_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:      rsp_ready <= ($urandom_range(0, 4) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_status = rsp_data;
         if (expected_status.size() == 0) begin
            $error("status word with no query waiting: %h", got_status);
            error_count++;
         end else begin
            want_status = expected_status.pop_front();
            if (got_status.held_count !== want_status.held_count) begin
               $error("held_count: expected %0d, got %0d",
                      want_status.held_count, got_status.held_count);
               error_count++;
            end
            if (got_status.short_press !== want_status.short_press) begin
               $error("short_press: expected %0d, got %0d",
                      want_status.short_press, got_status.short_press);
               error_count++;
            end
            if (got_status.long_press !== want_status.long_press) begin
               $error("long_press: expected %0d, got %0d",
                      want_status.long_press, got_status.long_press);
               error_count++;
            end
            if (got_status.bad_index !== want_status.bad_index) begin
               $error("bad_index: expected %0d, got %0d",
                      want_status.bad_index, got_status.bad_index);
               error_count++;
            end
         end
      end
   end

   task automatic push_word(logic [1:0] cmd, logic [PORT_BITS-1:0] pins, logic [2:0] idx);
      req_type w;
      w.command = cmd;
      w.port_sample = pins;
      w.button_index = idx;
      pending_words.push_back(w);
   endtask

   task automatic push_random_words(int n, int query_pct);
      req_type w;
      int      roll;
      int      run_max;
      run_max = (hold_cfg < 30) ? hold_cfg + 4 : 30;
      repeat (n) begin
         roll = $urandom_range(0, 99);
         w.port_sample = PORT_BITS'($urandom);
         w.button_index = 3'($urandom);
         if (roll < query_pct) begin
            w.command = $urandom_range(0, 1) ? CMD_QUERY_CLEAR : CMD_QUERY;
         end else if (roll < query_pct + 3) begin
            w.command = CMD_UNUSED;
         end else begin
            w.command = CMD_TICK;
            if (run_left == 0) begin
               held_pattern = PORT_BITS'($urandom);
               run_left = $urandom_range(1, run_max);
            end
            w.port_sample = held_pattern;
            // Now and then a pin bounces in the middle of a run.
            if ($urandom_range(0, 15) == 0)
               w.port_sample = w.port_sample ^ PORT_BITS'($urandom);
            run_left--;
         end
         pending_words.push_back(w);
      end
   endtask

   // Returns at a falling edge once the block has nothing left in flight.
   task automatic wait_idle();
      @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_status.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic regsel, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({regsel, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (regsel == REG_HOLD_TICKS)
         hold_cfg = value[COUNT_W-1:0];
      else
         press_cfg = value[0];
      @(negedge clock);
   endtask

   task automatic set_mode(int hold, logic level);
      wait_idle();
      csr_write(REG_HOLD_TICKS, hold);
      csr_write(REG_PRESS_LEVEL, CSR_DATA_W'(level));
      run_left = 0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Out of reset both samples sit at level 0, which reads as pressed.
      push_word(CMD_QUERY, 6'h00, 3'd0);
      push_word(CMD_TICK, 6'h00, 3'd0);
      push_word(CMD_QUERY, 6'h00, 3'd0);
      push_word(CMD_TICK, 6'h3F, 3'd7);
      push_word(CMD_TICK, 6'h3F, 3'd7);
      push_word(CMD_QUERY_CLEAR, 6'h3F, 3'd0);
      push_word(CMD_QUERY, 6'h00, 3'd0);
      push_word(CMD_TICK, 6'h15, 3'd0);
      push_word(CMD_TICK, 6'h15, 3'd0);
      push_word(CMD_QUERY_CLEAR, 6'h00, 3'd2);
      push_word(CMD_QUERY, 6'h00, 3'd6);
      push_word(CMD_QUERY_CLEAR, 6'h3F, 3'd7);
      push_word(CMD_UNUSED, 6'h2A, 3'd5);
      push_word(CMD_QUERY, 6'h00, 3'd5);

      // Active high with the shortest hold: a release after a long press
      // must not report a short press.
      set_mode(1, 1'b1);
      push_word(CMD_TICK, 6'h3F, 3'd0);
      push_word(CMD_TICK, 6'h3F, 3'd0);
      push_word(CMD_TICK, 6'h3F, 3'd0);
      push_word(CMD_QUERY, 6'h00, 3'd4);
      push_word(CMD_TICK, 6'h00, 3'd0);
      push_word(CMD_TICK, 6'h00, 3'd0);
      push_word(CMD_QUERY, 6'h00, 3'd4);

      // With a zero hold the long press flag sets on the first stable tick.
      set_mode(0, 1'b1);
      push_word(CMD_TICK, 6'h01, 3'd0);
      push_word(CMD_TICK, 6'h01, 3'd0);
      push_word(CMD_QUERY, 6'h00, 3'd0);

      set_mode(3, 1'b0);
      push_random_words(40, 40);
      set_mode(1, 1'b1);
      push_random_words(30, 40);

      // Long hold-off at the receiver while mostly queries keep coming.
      wait_idle();
      stall_asked++;
      push_random_words(40, 85);

      // The largest hold needs a long unbroken press before the flag sets.
      set_mode(255, 1'b0);
      repeat (258) begin
         if ($urandom_range(0, 15) == 0)
            push_word(CMD_QUERY, 6'h00, 3'($urandom_range(0, BUTTONS - 1)));
         push_word(CMD_TICK, 6'h00, 3'($urandom));
      end
      for (int b = 0; b < BUTTONS; b++)
         push_word(CMD_QUERY, 6'h00, 3'(b));
      push_word(CMD_TICK, 6'h3F, 3'd0);
      push_word(CMD_TICK, 6'h3F, 3'd0);
      push_word(CMD_QUERY_CLEAR, 6'h00, 3'd1);
      push_random_words(20, 40);

      set_mode(0, 1'b1);
      push_random_words(20, 40);
      set_mode($urandom_range(2, 12), 1'($urandom_range(0, 1)));
      push_random_words(30, 40);
      set_mode($urandom_range(2, 12), 1'($urandom_range(0, 1)));
      push_random_words(30, 40);
      set_mode(100, 1'b0);
      push_random_words(20, 40);

      wait_idle();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== button_debounce_press_hold.f =====
rtl/bdph_pkg.sv
rtl/button_debounce_press_hold.sv
rtl/bdph_checker.sv
sim/button_debounce_press_hold_tb.sv
